FILE: design/smbm_pkg.sv
`default_nettype none

package smbm_pkg;

  localparam int unsigned NUMER_W = 6;
  localparam int unsigned DENOM_W = 6;
  localparam int unsigned REM_W   = 5;
  localparam int unsigned STEPS   = 6;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CPU   = 2'd1;
  localparam logic [1:0] CMD_PPU   = 2'd2;

  localparam logic [1:0] TGT_PRG = 2'd0;
  localparam logic [1:0] TGT_CHR = 2'd1;
  localparam logic [1:0] TGT_NT  = 2'd2;

  localparam logic [1:0] SEL_CTRL   = 2'd0;
  localparam logic [1:0] SEL_CHR_LO = 2'd1;
  localparam logic [1:0] SEL_CHR_HI = 2'd2;
  localparam logic [1:0] SEL_PRG    = 2'd3;

  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;

  localparam logic [1:0] MIR_ONE_LO = 2'd0;
  localparam logic [1:0] MIR_ONE_HI = 2'd1;
  localparam logic [1:0] MIR_VERT   = 2'd2;

  localparam logic [4:0]  SHIFT_MARK   = 5'h10;
  localparam logic [4:0]  CTRL_RESET   = 5'h1e;
  localparam logic [4:0]  CTRL_LAST    = 5'h0c;
  localparam logic [4:0]  RENDER_MASK  = 5'h13;
  localparam logic [15:0] WINDOW_16K   = 16'h4000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [17:0] mapped_address;
    logic [1:0]  target_memory;
    logic        vertical_mirror;
    logic        render_changed;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

`default_nettype wire

FILE: design/serial_bank_mapper_five_bit_unit.sv
// Serial-load cartridge bank mapper.
// Items arrive on the input channel (in_valid_i / in_ready_o) as a command,
// an address and a data byte; each item gives exactly one result on the
// output channel (out_valid_o / out_ready_i): a translated byte offset, the
// memory it lands in, the vertical mirroring flag and a render change flag.
// Register writes load the five-bit shifter one bit at a time and commit on
// the fifth bit; lookups translate CPU or PPU addresses through the banks.
// The user must set the bank counts through the configuration write port
// only while idle; the block itself does not enforce it. One item is taken
// at a time. An item that needs a reduction by a bank count goes through the
// shared remainder unit, which works one quotient bit per cycle over six
// steps; every other item goes from execution straight to finishing. The
// result is registered. A finished result waits in the output register while
// the next item is accepted and worked on; if the receiver still stalls, the
// block holds the following result until the register is free.
// Reset loads the shifter with its marker, control with the fixed-last
// program mode and 4K pattern mode, clears the banks, and sets the counts
// to sixteen program banks and thirty-two pattern banks.
`default_nettype none

module serial_bank_mapper_five_bit_unit #(
  parameter int unsigned PRG_BANK_LOG2 = 14,
  parameter int unsigned CHR_BANK_LOG2 = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire smbm_pkg::item_t  in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output smbm_pkg::result_t     out_result_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [5:0]       cfg_data_i
);
  import smbm_pkg::*;

  localparam int unsigned PW = PRG_BANK_LOG2 + 6;
  localparam int unsigned CW = CHR_BANK_LOG2 + 6;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_e;

  state_e      state_q;
  item_t       item_q;
  result_t     out_q;
  result_t     res_d;
  logic        out_valid_q;
  logic        changed_q;
  logic [4:0]  prg_count_q;
  logic [5:0]  chr_count_q;
  logic [4:0]  shifter_q;
  logic [4:0]  ctrl_q;
  logic [4:0]  chr_lo_q;
  logic [4:0]  chr_hi_q;
  logic [4:0]  prg_bank_q;

  logic [4:0]  prg_eff;
  logic [5:0]  chr_eff;
  logic [4:0]  wr_val;
  logic [1:0]  wr_sel;
  logic [PW-1:0] prg_off;
  logic [CW-1:0] chr_off;
  logic [4:0]  half_bank;
  logic        nt_page;
  logic [PRG_BANK_LOG2+4:0] prg_full;
  logic [CHR_BANK_LOG2+4:0] chr_full;

  logic                 div_start;
  logic [NUMER_W-1:0]   div_numer;
  logic [DENOM_W-1:0]   div_denom;
  rem_status_t          div_status;
  logic [REM_W-1:0]     div_rem;

  always_comb begin
    if (prg_count_q == 5'd0) begin
      prg_eff = 5'd1;
    end else if (prg_count_q > 5'd16) begin
      prg_eff = 5'd16;
    end else begin
      prg_eff = prg_count_q;
    end
    if (chr_count_q == 6'd0) begin
      chr_eff = 6'd1;
    end else if (chr_count_q > 6'd32) begin
      chr_eff = 6'd32;
    end else begin
      chr_eff = chr_count_q;
    end
  end

  assign wr_val = {item_q.data[0], shifter_q[4:1]};
  assign wr_sel = item_q.address[14:13];

  always_comb begin
    case (ctrl_q[3:2])
      PRG_FIX_FIRST: begin
        if (item_q.address[14]) begin
          prg_off = (PW'(prg_bank_q[3:0]) << PRG_BANK_LOG2) + PW'(item_q.address[13:0]);
        end else begin
          prg_off = PW'(item_q.address[13:0]);
        end
      end
      PRG_FIX_LAST: begin
        if (item_q.address[14]) begin
          prg_off = (PW'(prg_eff) << (PRG_BANK_LOG2 + 2)) + PW'(item_q.address[13:0])
                    - PW'(WINDOW_16K);
        end else begin
          prg_off = (PW'(prg_bank_q[3:0]) << PRG_BANK_LOG2) + PW'(item_q.address[13:0]);
        end
      end
      default: begin
        prg_off = (PW'({prg_bank_q[3:1], 1'b0}) << PRG_BANK_LOG2)
                  + PW'(item_q.address[14:0]);
      end
    endcase
  end

  always_comb begin
    half_bank = item_q.address[12] ? chr_hi_q : chr_lo_q;
    if (ctrl_q[4]) begin
      chr_off = (CW'(half_bank) << CHR_BANK_LOG2) + CW'(item_q.address[11:0]);
    end else begin
      chr_off = (CW'({chr_lo_q[4:1], 1'b0}) << CHR_BANK_LOG2) + CW'(item_q.address[12:0]);
    end
  end

  always_comb begin
    case (ctrl_q[1:0])
      MIR_ONE_LO: nt_page = 1'b0;
      MIR_ONE_HI: nt_page = 1'b1;
      MIR_VERT:   nt_page = item_q.address[10];
      default:    nt_page = item_q.address[11];
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_numer = {1'b0, wr_val};
    div_denom = chr_eff;
    if (state_q == S_EXEC) begin
      case (item_q.command)
        CMD_WRITE: begin
          if (item_q.address[15] && !item_q.data[7] && shifter_q[0]
              && wr_sel != SEL_CTRL) begin
            div_start = 1'b1;
            div_denom = (wr_sel == SEL_PRG) ? DENOM_W'(prg_eff) : chr_eff;
          end
        end
        CMD_CPU: begin
          div_start = 1'b1;
          div_numer = prg_off[PW-1:PRG_BANK_LOG2];
          div_denom = DENOM_W'(prg_eff);
        end
        CMD_PPU: begin
          div_start = !item_q.address[13];
          div_numer = chr_off[CW-1:CHR_BANK_LOG2];
        end
        default: begin
          div_start = 1'b0;
        end
      endcase
    end
  end

  smbm_rem_unit u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (div_numer),
    .denom_i  (div_denom),
    .status_o (div_status),
    .rem_o    (div_rem)
  );

  assign prg_full = {div_rem, prg_off[PRG_BANK_LOG2-1:0]};
  assign chr_full = {div_rem, chr_off[CHR_BANK_LOG2-1:0]};

  always_comb begin
    res_d.mapped_address  = '0;
    res_d.target_memory   = TGT_PRG;
    res_d.vertical_mirror = (ctrl_q[1:0] == MIR_VERT);
    res_d.render_changed  = changed_q;
    case (item_q.command)
      CMD_CPU: begin
        res_d.mapped_address = 18'(prg_full);
      end
      CMD_PPU: begin
        if (item_q.address[13]) begin
          res_d.mapped_address = 18'({nt_page, item_q.address[9:0]});
          res_d.target_memory  = TGT_NT;
        end else begin
          res_d.mapped_address = 18'(chr_full);
          res_d.target_memory  = TGT_CHR;
        end
      end
      default: begin
        res_d.mapped_address = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
      item_q      <= '0;
      out_q       <= '0;
      prg_count_q <= 5'd16;
      chr_count_q <= 6'd32;
      shifter_q   <= SHIFT_MARK;
      ctrl_q      <= CTRL_RESET;
      chr_lo_q    <= '0;
      chr_hi_q    <= '0;
      prg_bank_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRG_COUNT: prg_count_q <= cfg_data_i[4:0];
          CFG_CHR_COUNT: chr_count_q <= cfg_data_i;
          default:       chr_count_q <= cfg_data_i;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= div_start ? S_DIV : S_FIN;
          if (item_q.command == CMD_WRITE && item_q.address[15]) begin
            if (item_q.data[7]) begin
              changed_q <= 1'b0;
              shifter_q <= SHIFT_MARK;
              ctrl_q    <= ctrl_q | CTRL_LAST;
            end else if (!shifter_q[0]) begin
              changed_q <= 1'b0;
              shifter_q <= wr_val;
            end else begin
              shifter_q <= SHIFT_MARK;
              case (wr_sel)
                SEL_CTRL: begin
                  changed_q <= |((ctrl_q ^ wr_val) & RENDER_MASK);
                  ctrl_q    <= wr_val;
                end
                SEL_CHR_LO: changed_q <= |(chr_lo_q ^ wr_val);
                SEL_CHR_HI: changed_q <= |(chr_hi_q ^ wr_val);
                default:    changed_q <= 1'b0;
              endcase
            end
          end else begin
            changed_q <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state_q <= S_FIN;
            if (item_q.command == CMD_WRITE) begin
              case (wr_sel)
                SEL_CHR_LO: chr_lo_q   <= div_rem;
                SEL_CHR_HI: chr_hi_q   <= div_rem;
                SEL_PRG:    prg_bank_q <= div_rem;
                default:    prg_bank_q <= prg_bank_q;
              endcase
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

FILE: design/smbm_rem_unit.sv
`default_nettype none

module smbm_rem_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [smbm_pkg::NUMER_W-1:0] numer_i,
  input  wire logic [smbm_pkg::DENOM_W-1:0] denom_i,
  output smbm_pkg::rem_status_t            status_o,
  output logic [smbm_pkg::REM_W-1:0]       rem_o
);
  import smbm_pkg::*;

  logic [NUMER_W-1:0] num_q;
  logic [DENOM_W-1:0] den_q;
  logic [REM_W-1:0]   rem_q;
  logic [REM_W-1:0]   rem_d;
  logic [2:0]         cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [REM_W:0]     trial;

  always_comb begin
    trial = {rem_q, num_q[NUMER_W-1]};
    if (trial >= den_q) begin
      rem_d = REM_W'(trial - den_q);
    end else begin
      rem_d = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= numer_i;
      den_q <= denom_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUMER_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

`default_nettype wire
